// ===== design/assert_macros.svh =====
// Assertion macros for the checksum RTL, used by fl32_acc.
// Each macro expects clk and arst_n to be visible in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define FL32_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("checksum assertion failed");

// Next-cycle implication, checked outside reset
`define FL32_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("checksum assertion failed");

`endif

// ===== design/fl32_pkg.sv =====
// Shared types, constants and the 16-bit fold for the byte checksum.
// No dependencies; used by fl32_acc, fl32_fin and the top level.
package fl32_pkg;

	localparam int          CHUNK_WORDS_DEF = 359;
	localparam logic [31:0] SUM_INIT        = 32'h0000_FFFF;

	// Raw (unfolded) sum pair handed from the accumulator to the finish stages
	typedef struct packed {
		logic [31:0] first;
		logic [31:0] second;
	} sums_t;

	// Low 16 bits plus the bits above them
	function automatic logic [31:0] fold16(input logic [31:0] v);
		return 32'(v[15:0]) + 32'(v[31:16]);
	endfunction

endpackage

// ===== design/fl32_acc.sv =====
// Running-sum accumulator: pairs bytes into words and updates both sums.
// Depends on fl32_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fl32_acc #(
	parameter int CHUNK_WORDS = fl32_pkg::CHUNK_WORDS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	input  logic [7:0]      item_byte,
	input  logic            item_last,
	input  logic            fin_ready,
	output logic            fire,
	output logic            valid_s2,
	output fl32_pkg::sums_t sums_s2
);

	localparam int CntW = $clog2(CHUNK_WORDS + 1);

	logic [31:0]     first_q, second_q;
	logic [7:0]      held_q;
	logic            odd_q;
	logic            pend_q;   // fold owed at the chunk boundary, applied on next use
	logic [CntW-1:0] cnt_q;

	logic            s2_free;
	logic            use_fold;
	logic [31:0]     first_op, second_op, word, first_add, second_add;
	logic [CntW-1:0] cnt_inc;

	// Handshake toward the finish stages; non-final bytes never wait
	assign s2_free = !valid_s2 || fin_ready;
	assign fire    = item_valid && (!item_last || s2_free);

	// Operand selection with any owed fold, then the word add
	assign use_fold  = pend_q || (!odd_q && (cnt_q != '0));
	assign first_op  = use_fold ? fl32_pkg::fold16(first_q)  : first_q;
	assign second_op = use_fold ? fl32_pkg::fold16(second_q) : second_q;
	assign word      = odd_q ? {16'h0000, held_q, item_byte} : {16'h0000, item_byte, 8'h00};
	assign first_add  = first_op + word;
	assign second_add = second_op + first_op + word;
	assign cnt_inc    = cnt_q + CntW'(1);

	// Sum state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q  <= fl32_pkg::SUM_INIT;
			second_q <= fl32_pkg::SUM_INIT;
			held_q   <= '0;
			odd_q    <= 1'b0;
			pend_q   <= 1'b0;
			cnt_q    <= '0;
		end else if (fire) begin
			if (item_last) begin
				first_q  <= fl32_pkg::SUM_INIT;
				second_q <= fl32_pkg::SUM_INIT;
				held_q   <= '0;
				odd_q    <= 1'b0;
				pend_q   <= 1'b0;
				cnt_q    <= '0;
			end else if (odd_q) begin
				first_q  <= first_add;
				second_q <= second_add;
				odd_q    <= 1'b0;
				if (cnt_inc >= CntW'(CHUNK_WORDS)) begin
					cnt_q  <= '0;
					pend_q <= 1'b1;
				end else begin
					cnt_q  <= cnt_inc;
					pend_q <= 1'b0;
				end
			end else begin
				held_q <= item_byte;
				odd_q  <= 1'b1;
			end
		end
	end

	// Stage 2 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire && item_last) begin
			valid_s2 <= 1'b1;
		end else if (fin_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// Stage 2 payload: raw sums, still owing two folds
	always_ff @(posedge clk) begin
		if (fire && item_last) begin
			sums_s2.first  <= first_add;
			sums_s2.second <= second_add;
		end
	end

	`FL32_ASSERT_NOW(a_pend_at_boundary, pend_q, cnt_q == '0)
	`FL32_ASSERT_NOW(a_cnt_in_chunk, 1'b1, cnt_q < CntW'(CHUNK_WORDS))
	`FL32_ASSERT_NEXT(a_clear_after_last, fire && item_last,
		!odd_q && !pend_q && (cnt_q == '0) && (first_q == fl32_pkg::SUM_INIT))

endmodule

// ===== design/fl32_fin.sv =====
// Finish stages: two folds of the raw sums and the output register.
// Depends on fl32_pkg.
module fl32_fin (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            sums_valid,
	input  fl32_pkg::sums_t sums,
	output logic            ready,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [31:0]     checksum
);

	logic        valid_s3;
	logic [16:0] first_s3, second_s3;
	logic        out_free;
	logic [31:0] first_f1, second_f1, first_f2, second_f2;

	assign out_free = !out_valid || !out_stall;
	assign ready    = !valid_s3 || out_free;

	// First fold fits in 17 bits
	assign first_f1  = fl32_pkg::fold16(sums.first);
	assign second_f1 = fl32_pkg::fold16(sums.second);

	// Second fold
	assign first_f2  = fl32_pkg::fold16({15'h0000, first_s3});
	assign second_f2 = fl32_pkg::fold16({15'h0000, second_s3});

	// Valid bits for stage 3 and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (ready) begin
				valid_s3 <= sums_valid;
			end
			if (out_free) begin
				out_valid <= valid_s3;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (ready && sums_valid) begin
			first_s3  <= first_f1[16:0];
			second_s3 <= second_f1[16:0];
		end
		if (out_free && valid_s3) begin
			checksum <= {second_f2[15:0], first_f2[15:0]};
		end
	end

endmodule

// ===== design/fletcher32_byte_checksum_top.sv =====
// Fletcher-32 style checksum over a byte stream, one byte per transaction.
// Input channel: data_byte/last_byte with in_valid/in_stall. Bytes pair
// big-endian into 16-bit words; last_byte marks the final byte of a message.
// Output channel: checksum with out_valid/out_stall, one transaction per
// message, sum2 in bits 31:16 and sum1 in bits 15:0.
// Throughput: one byte per cycle while a final byte is not held by the finish stages;
// the sum update is a single registered step fed by the input register, so back-to-back messages also run at full rate.
// Path: after the final byte is accepted into the input register, the accumulate step
// loads the raw sums, the first fold loads stage 3 and the second fold loads the output register.
// Stall: a stalled result holds in the output register; two more results can
// queue in stage 2 and stage 3 before in_stall rises, and only a final byte waits
// on them. Non-final bytes keep flowing.
// Reset (arst_n low): sums return to 0xFFFF, pairing and chunk count clear,
// all pipeline stages empty. The state also self-clears after every message.
// Depends on fl32_pkg, fl32_acc, fl32_fin.
module fletcher32_byte_checksum_top #(
	parameter int CHUNK_WORDS = fl32_pkg::CHUNK_WORDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] checksum
);

	logic            valid_s1;
	logic [7:0]      byte_s1;
	logic            last_s1;
	logic            fire;
	logic            accept;
	logic            valid_s2;
	logic            fin_ready;
	fl32_pkg::sums_t sums_s2;

	// Input register handshake
	assign in_stall = valid_s1 && !fire;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	fl32_acc #(
		.CHUNK_WORDS (CHUNK_WORDS)
	) u_acc (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (valid_s1),
		.item_byte  (byte_s1),
		.item_last  (last_s1),
		.fin_ready  (fin_ready),
		.fire       (fire),
		.valid_s2   (valid_s2),
		.sums_s2    (sums_s2)
	);

	fl32_fin u_fin (
		.clk        (clk),
		.arst_n     (arst_n),
		.sums_valid (valid_s2),
		.sums       (sums_s2),
		.ready      (fin_ready),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.checksum   (checksum)
	);

endmodule

// ===== sim/tb_fletcher32_byte_checksum_top.sv =====
// Self-checking testbench for fletcher32_byte_checksum_top: directed, chunk-boundary,
// random and back-pressure message streams checked against an in-bench checksum predictor.
// Depends on fl32_pkg and the checksum RTL only.
`timescale 1ns / 1ps

module tb_fletcher32_byte_checksum_top;

	localparam int CHUNK_WORDS = fl32_pkg::CHUNK_WORDS_DEF;
	localparam int HOLD_CYCLES = 400;   // long receiver hold-off
	localparam int IDLE_LIMIT  = 2000;  // cycles with no transaction before giving up
	localparam int RANDOM_ITEMS = 400;
	localparam int RANDOM_MSGS  = 30;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        last_byte;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] checksum;

	// Receiver stall is the OR of the per-transaction gap and the long hold-off
	logic rx_stall;
	logic hold_stall;
	bit   hold_req;
	assign out_stall = rx_stall | hold_stall;

	bit tx_gaps_on;
	bit rx_gaps_on;
	int unsigned fail_count;
	int unsigned idle_cycles;

	// Predictor state
	logic [31:0] run_sum1;
	logic [31:0] run_sum2;
	logic [7:0]  high_byte_hold;
	logic        high_byte_waiting;
	logic [8:0]  chunk_word_count;
	logic [31:0] pending_checksums[$];
	logic [31:0] oldest_checksum;

	fletcher32_byte_checksum_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.checksum  (checksum)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ---------------- predictor ----------------

	function automatic logic [31:0] fold_halves(logic [31:0] v);
		return {16'h0000, v[15:0]} + {16'h0000, v[31:16]};
	endfunction

	function automatic void fold_sums();
		run_sum1 = fold_halves(run_sum1);
		run_sum2 = fold_halves(run_sum2);
	endfunction

	function automatic void add_word16(logic [15:0] w);
		run_sum1 = run_sum1 + {16'h0000, w};
		run_sum2 = run_sum2 + run_sum1;
	endfunction

	function automatic void clear_predictor();
		run_sum1          = 32'h0000_FFFF;
		run_sum2          = 32'h0000_FFFF;
		high_byte_hold    = 8'h00;
		high_byte_waiting = 1'b0;
		chunk_word_count  = 9'd0;
	endfunction

	// Update the running sums with one accepted byte; queue the checksum on the final byte
	function automatic void absorb_byte(logic [7:0] b, logic fin);
		if (high_byte_waiting) begin
			add_word16({high_byte_hold, b});
			high_byte_waiting = 1'b0;
			chunk_word_count  = chunk_word_count + 9'd1;
			if (chunk_word_count >= CHUNK_WORDS || fin) begin
				if (chunk_word_count != 0)
					fold_sums();
				chunk_word_count = 9'd0;
			end
		end else if (fin) begin
			// odd trailing byte: flush pending words, then add it as a high half
			if (chunk_word_count != 0)
				fold_sums();
			chunk_word_count = 9'd0;
			add_word16({b, 8'h00});
			fold_sums();
		end else begin
			high_byte_hold    = b;
			high_byte_waiting = 1'b1;
		end
		if (fin) begin
			fold_sums();
			pending_checksums.push_back({run_sum2[15:0], run_sum1[15:0]});
			clear_predictor();
		end
	endfunction

	// ---------------- monitor and checker ----------------

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_checksums.size() == 0) begin
					$error("checksum: no transaction expected, actual %h", checksum);
					fail_count++;
				end else begin
					oldest_checksum = pending_checksums.pop_front();
					if (checksum !== oldest_checksum) begin
						$error("checksum: expected %h, actual %h", oldest_checksum, checksum);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall)
				absorb_byte(data_byte, last_byte);
		end
	end

	// ---------------- watchdog ----------------

	initial begin
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("tb_fletcher32_byte_checksum_top: FAIL");
		$finish;
	end

	// ---------------- receiver ----------------

	initial begin : receiver
		int unsigned gap;
		rx_stall <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			gap = rx_gaps_on ? $urandom_range(0, 6) : 0;
			if (gap != 0) begin
				rx_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			rx_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	// Long hold-off, counted here so the sender keeps offering bytes meanwhile
	initial begin : long_hold
		hold_stall <= 1'b0;
		forever begin
			wait (hold_req);
			@(posedge clk);
			hold_stall <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			hold_stall <= 1'b0;
			hold_req = 1'b0;
		end
	end

	// ---------------- sender ----------------

	task automatic send_byte(input logic [7:0] b, input logic fin);
		int unsigned gap;
		gap = tx_gaps_on ? $urandom_range(0, 6) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		last_byte <= fin;
		do @(posedge clk); while (in_stall);
	endtask

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 9))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic send_fill_message(input int unsigned n_bytes, input logic [7:0] value);
		for (int unsigned i = 0; i < n_bytes; i++)
			send_byte(value, i == n_bytes - 1);
	endtask

	task automatic send_random_message(input int unsigned n_bytes);
		for (int unsigned i = 0; i < n_bytes; i++)
			send_byte(pick_byte(), i == n_bytes - 1);
	endtask

	// ---------------- tests ----------------

	// One-byte messages: odd final byte with nothing pending
	task automatic test_single_byte_messages();
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h80, 1'b1);
	endtask

	// Short messages ending on a full word and on an odd byte after words
	task automatic test_short_messages();
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'h01, 1'b1);
		send_byte(8'h12, 1'b0);
		send_byte(8'h34, 1'b0);
		send_byte(8'hAB, 1'b1);
		send_byte(8'hA5, 1'b0);
		send_byte(8'h5A, 1'b0);
		send_byte(8'hC3, 1'b0);
		send_byte(8'h3C, 1'b1);
		send_fill_message(5, 8'hFF);
	endtask

	// A full chunk, then a word that carries the chunk fold, then an odd final byte
	task automatic test_chunk_boundary();
		send_random_message(2 * (CHUNK_WORDS + 1) + 1);
	endtask

	// Random lengths: mostly short, some medium
	task automatic test_random_messages();
		int unsigned items_sent;
		int unsigned msgs_sent;
		int unsigned len;
		int unsigned pick;
		items_sent = 0;
		msgs_sent  = 0;
		while (items_sent < RANDOM_ITEMS || msgs_sent < RANDOM_MSGS) begin
			pick = $urandom_range(0, 99);
			if (pick < 85)
				len = $urandom_range(1, 16);
			else
				len = $urandom_range(17, 60);
			// some messages run with no idling on either side
			tx_gaps_on = ($urandom_range(0, 4) != 0);
			rx_gaps_on = ($urandom_range(0, 4) != 0);
			send_random_message(len);
			items_sent += len;
			msgs_sent++;
		end
		tx_gaps_on = 1'b1;
		rx_gaps_on = 1'b1;
	endtask

	// Receiver holds off while short messages pile up until in_stall rises
	task automatic test_output_backpressure();
		tx_gaps_on = 1'b0;
		hold_req   = 1'b1;
		for (int i = 0; i < 8; i++)
			send_random_message($urandom_range(1, 3));
		wait (!hold_req);
		tx_gaps_on = 1'b1;
	endtask

	// ---------------- main sequence ----------------

	initial begin
		fail_count = 0;
		tx_gaps_on = 1'b1;
		rx_gaps_on = 1'b1;
		hold_req   = 1'b0;
		clear_predictor();
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		data_byte <= 8'h00;
		last_byte <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_single_byte_messages();
		test_short_messages();
		test_chunk_boundary();
		test_output_backpressure();
		test_random_messages();
		in_valid <= 1'b0;

		while (pending_checksums.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("tb_fletcher32_byte_checksum_top: PASS");
		else
			$display("tb_fletcher32_byte_checksum_top: FAIL");
		$finish;
	end

endmodule
